@@ sv/rotation_matrix_generator_assert.svh @@
// ----------------------------------------------------------------------------
// Rotation matrix generator assertion macros
// Shorthand for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_GENERATOR_ASSERT_SVH
`define ROTATION_MATRIX_GENERATOR_ASSERT_SVH

// Consequent checked in the same cycle.
`define RMG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the next cycle.
`define RMG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rmg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix generator package
// Widths, fixed-point constants, mode codes and lookup functions.
// ----------------------------------------------------------------------------
package rmg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int WORK_BITS        = 28;

    localparam int FUNC_W = 3;
    localparam int ANG_W  = 20;
    localparam int AXIS_W = 16;
    localparam int ELEM_W = 18;
    localparam int RED_W  = 37;   // reduced angle, Q30 with headroom
    localparam int CW     = 34;   // CORDIC datapath
    localparam int MW     = 40;   // matrix entries before output scaling

    localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 37'sd6746518852;
    localparam logic signed [RED_W-1:0] PI_Q30      = 37'sd3373259426;
    localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 37'sd1686629713;
    localparam logic signed [CW-1:0]    GAIN_Q30    = 34'sd652032874;
    localparam logic signed [MW-1:0]    ONE_Q28     = 40'sd268435456;
    localparam logic signed [MW-1:0]    ZERO_Q28    = 40'sd0;
    localparam logic signed [MW-1:0]    OUT_MAX     = 40'sd131071;
    localparam logic signed [MW-1:0]    OUT_MIN     = -40'sd131072;

    localparam logic [FUNC_W-1:0] FUNC_AXIS = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_XY   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_XZ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_YZ   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_XW   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_ZW   = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_YW   = 3'd6;

    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        logic                     neg;
    } rmg_meta_t;

    // Sixteen output entries, index row*4 + column
    typedef logic [15:0][ELEM_W-1:0] rmg_mat_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // First and second axis of each plane mode
    function automatic logic [1:0] plane_a(input logic [FUNC_W-1:0] f);
        logic [1:0] v;
        unique case (f)
            FUNC_YZ: v = 2'd1;
            FUNC_ZW: v = 2'd2;
            FUNC_YW: v = 2'd1;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] plane_b(input logic [FUNC_W-1:0] f);
        logic [1:0] v;
        unique case (f)
            FUNC_XY: v = 2'd1;
            FUNC_XZ: v = 2'd2;
            FUNC_YZ: v = 2'd2;
            FUNC_XW: v = 2'd3;
            FUNC_ZW: v = 2'd3;
            FUNC_YW: v = 2'd3;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/rmg_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix generator channels
// Valid/ready interfaces for the request and row result channels.
// ----------------------------------------------------------------------------
interface rmg_in_if import rmg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [ANG_W-1:0]  angle;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;

    modport source (output valid, func, angle, axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, func, angle, axis_x, axis_y, axis_z, output ready);
endinterface

interface rmg_out_if import rmg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               row;
    logic signed [ELEM_W-1:0] elem0;
    logic signed [ELEM_W-1:0] elem1;
    logic signed [ELEM_W-1:0] elem2;
    logic signed [ELEM_W-1:0] elem3;
    logic                     last;

    modport source (output valid, row, elem0, elem1, elem2, elem3, last, input ready);
    modport sink   (input valid, row, elem0, elem1, elem2, elem3, last, output ready);
endinterface

@@ sv/rmg_angle_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle reduction
// Three stages: wrap into [0, 2pi), recenter to (-pi, pi], fold to +-pi/2.
// ----------------------------------------------------------------------------
module rmg_angle_reduce
    import rmg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [ANG_W-1:0] angle,
    input  rmg_meta_t               in_meta,
    output logic                    out_valid,
    output logic signed [CW-1:0]    r,
    output rmg_meta_t               out_meta
);

    logic signed [RED_W-1:0] r0;
    logic signed [RED_W-1:0] r1_next;
    logic signed [RED_W-1:0] r1_reg;
    logic signed [RED_W-1:0] r2;
    logic signed [RED_W-1:0] r3_next;
    logic signed [RED_W-1:0] r3_reg;
    logic signed [RED_W-1:0] r4_next;
    logic signed [CW-1:0]    r4_reg;
    logic                    neg_next;
    logic [2:0]              valid_reg;
    rmg_meta_t               m1_reg;
    rmg_meta_t               m2_reg;
    rmg_meta_t               m3_next;
    rmg_meta_t               m3_reg;

    // Widen Q4.16 to Q30
    assign r0 = {{(RED_W - ANG_W - 14){angle[ANG_W-1]}}, angle, 14'b0};

    always_comb
    begin
        if (r0 >= TWO_PI_Q30)
        begin
            r1_next = r0 - TWO_PI_Q30;
        end
        else if (r0 < 0)
        begin
            r1_next = r0 + TWO_PI_Q30;
        end
        else
        begin
            r1_next = r0;
        end
    end

    assign r2      = (r1_reg < 0) ? r1_reg + TWO_PI_Q30 : r1_reg;
    assign r3_next = (r2 > PI_Q30) ? r2 - TWO_PI_Q30 : r2;

    always_comb
    begin
        if (r3_reg > HALF_PI_Q30)
        begin
            r4_next  = r3_reg - PI_Q30;
            neg_next = 1'b1;
        end
        else if (r3_reg < -HALF_PI_Q30)
        begin
            r4_next  = r3_reg + PI_Q30;
            neg_next = 1'b1;
        end
        else
        begin
            r4_next  = r3_reg;
            neg_next = 1'b0;
        end
    end

    always_comb
    begin
        m3_next     = m2_reg;
        m3_next.neg = neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg <= r1_next;
            m1_reg <= in_meta;
            r3_reg <= r3_next;
            m2_reg <= m1_reg;
            r4_reg <= r4_next[CW-1:0];
            m3_reg <= m3_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign r         = r4_reg;
    assign out_meta  = m3_reg;

endmodule

@@ sv/rmg_cordic_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC stage
// One registered rotation-mode micro-rotation by atan(2^-IDX).
// ----------------------------------------------------------------------------
module rmg_cordic_stage
    import rmg_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] r_in,
    input  rmg_meta_t            in_meta,
    output logic                 out_valid,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] r_out,
    output rmg_meta_t            out_meta
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] ang;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] r_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] r_reg;
    logic                 valid_reg;
    rmg_meta_t            meta_reg;

    assign dx  = y_in >>> IDX;
    assign dy  = x_in >>> IDX;
    assign ang = signed'({{(CW - 32){1'b0}}, atan_q30(5'(IDX))});

    always_comb
    begin
        if (r_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            r_next = r_in - ang;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            r_next = r_in + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            r_reg    <= r_next;
            meta_reg <= in_meta;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign r_out     = r_reg;
    assign out_meta  = meta_reg;

endmodule

@@ sv/rmg_matrix_build.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix build
// Five stages: sign/round, axis products, scale by 1-cos, assemble, saturate.
// ----------------------------------------------------------------------------
module rmg_matrix_build
    import rmg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  rmg_meta_t            in_meta,
    output logic                 out_valid,
    output rmg_mat_t             mat
);

    localparam int SH = WORK_BITS - FRAC_BITS;

    logic [4:0] valid_reg;

    // Stage 1: undo fold, round to Q28, axis pair products
    logic signed [CW-1:0] xn;
    logic signed [CW-1:0] yn;
    logic signed [CW-1:0] c1_reg;
    logic signed [CW-1:0] s1_reg;
    logic signed [31:0]   pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg;
    rmg_meta_t            m1_reg;

    assign xn = in_meta.neg ? -x_in : x_in;
    assign yn = in_meta.neg ? -y_in : y_in;

    // Stage 2: axis times sine, one minus cosine
    logic signed [49:0]   txs, tys, tzs;
    logic signed [49:0]   rxs, rys, rzs;
    logic signed [MW-1:0] xs_reg, ys_reg, zs_reg;
    logic signed [CW-1:0] omc_reg;
    logic signed [CW-1:0] c2_reg;
    logic signed [CW-1:0] s2_reg;
    logic signed [31:0]   qxx_reg, qyy_reg, qzz_reg, qxy_reg, qxz_reg, qyz_reg;
    rmg_meta_t            m2_reg;

    assign txs = s1_reg * m1_reg.ax;
    assign tys = s1_reg * m1_reg.ay;
    assign tzs = s1_reg * m1_reg.az;
    assign rxs = (txs + 50'sd8192) >>> 14;
    assign rys = (tys + 50'sd8192) >>> 14;
    assign rzs = (tzs + 50'sd8192) >>> 14;

    // Stage 3: pair products scaled by 1 - cos
    logic signed [65:0]   mxx, myy, mzz, mxy, mxz, myz;
    logic signed [65:0]   rxx, ryy, rzz, rxy, rxz, ryz;
    logic signed [MW-1:0] oxx_reg, oyy_reg, ozz_reg, oxy_reg, oxz_reg, oyz_reg;
    logic signed [MW-1:0] xs3_reg, ys3_reg, zs3_reg;
    logic signed [MW-1:0] c3_reg;
    logic signed [MW-1:0] s3_reg;
    rmg_meta_t            m3_reg;

    assign mxx = qxx_reg * omc_reg;
    assign myy = qyy_reg * omc_reg;
    assign mzz = qzz_reg * omc_reg;
    assign mxy = qxy_reg * omc_reg;
    assign mxz = qxz_reg * omc_reg;
    assign myz = qyz_reg * omc_reg;
    assign rxx = (mxx + 66'sd134217728) >>> WORK_BITS;
    assign ryy = (myy + 66'sd134217728) >>> WORK_BITS;
    assign rzz = (mzz + 66'sd134217728) >>> WORK_BITS;
    assign rxy = (mxy + 66'sd134217728) >>> WORK_BITS;
    assign rxz = (mxz + 66'sd134217728) >>> WORK_BITS;
    assign ryz = (myz + 66'sd134217728) >>> WORK_BITS;

    // Stage 4: assemble the Q28 matrix
    logic signed [MW-1:0] a_next [16];
    logic signed [MW-1:0] a_reg  [16];
    logic [1:0]           pa;
    logic [1:0]           pb;

    assign pa = plane_a(m3_reg.func);
    assign pb = plane_b(m3_reg.func);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            a_next[i] = (i % 5 == 0) ? ONE_Q28 : ZERO_Q28;
        end
        if (m3_reg.func == FUNC_AXIS)
        begin
            a_next[0]  = oxx_reg + c3_reg;
            a_next[1]  = oxy_reg - zs3_reg;
            a_next[2]  = oxz_reg + ys3_reg;
            a_next[4]  = oxy_reg + zs3_reg;
            a_next[5]  = oyy_reg + c3_reg;
            a_next[6]  = oyz_reg - xs3_reg;
            a_next[8]  = oxz_reg - ys3_reg;
            a_next[9]  = oyz_reg + xs3_reg;
            a_next[10] = ozz_reg + c3_reg;
        end
        else if (m3_reg.func <= FUNC_YW)
        begin
            a_next[{pa, pa}] = c3_reg;
            a_next[{pa, pb}] = -s3_reg;
            a_next[{pb, pa}] = s3_reg;
            a_next[{pb, pb}] = c3_reg;
        end
    end

    // Stage 5: scale to output fraction bits and saturate
    logic signed [MW+1:0] v [16];
    rmg_mat_t             mat_reg;

    for (genvar g = 0; g < 16; g++)
    begin : g_conv
        logic signed [MW+1:0] qw;
        assign qw = {{2{a_reg[g][MW-1]}}, a_reg[g]};
        if (SH > 0)
        begin : g_rnd
            assign v[g] = (qw + (42'sd1 <<< (SH - 1))) >>> SH;
        end
        else if (SH == 0)
        begin : g_pass
            assign v[g] = qw;
        end
        else
        begin : g_up
            assign v[g] = qw <<< (-SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg  <= (xn + 34'sd2) >>> 2;
            s1_reg  <= (yn + 34'sd2) >>> 2;
            pxx_reg <= in_meta.ax * in_meta.ax;
            pyy_reg <= in_meta.ay * in_meta.ay;
            pzz_reg <= in_meta.az * in_meta.az;
            pxy_reg <= in_meta.ax * in_meta.ay;
            pxz_reg <= in_meta.ax * in_meta.az;
            pyz_reg <= in_meta.ay * in_meta.az;
            m1_reg  <= in_meta;

            xs_reg  <= rxs[MW-1:0];
            ys_reg  <= rys[MW-1:0];
            zs_reg  <= rzs[MW-1:0];
            omc_reg <= ONE_Q28[CW-1:0] - c1_reg;
            c2_reg  <= c1_reg;
            s2_reg  <= s1_reg;
            qxx_reg <= pxx_reg;
            qyy_reg <= pyy_reg;
            qzz_reg <= pzz_reg;
            qxy_reg <= pxy_reg;
            qxz_reg <= pxz_reg;
            qyz_reg <= pyz_reg;
            m2_reg  <= m1_reg;

            oxx_reg <= rxx[MW-1:0];
            oyy_reg <= ryy[MW-1:0];
            ozz_reg <= rzz[MW-1:0];
            oxy_reg <= rxy[MW-1:0];
            oxz_reg <= rxz[MW-1:0];
            oyz_reg <= ryz[MW-1:0];
            xs3_reg <= xs_reg;
            ys3_reg <= ys_reg;
            zs3_reg <= zs_reg;
            c3_reg  <= {{(MW - CW){c2_reg[CW-1]}}, c2_reg};
            s3_reg  <= {{(MW - CW){s2_reg[CW-1]}}, s2_reg};
            m3_reg  <= m2_reg;

            a_reg   <= a_next;

            for (int i = 0; i < 16; i++)
            begin
                if (v[i] > 42'(OUT_MAX))
                begin
                    mat_reg[i] <= OUT_MAX[ELEM_W-1:0];
                end
                else if (v[i] < 42'(OUT_MIN))
                begin
                    mat_reg[i] <= OUT_MIN[ELEM_W-1:0];
                end
                else
                begin
                    mat_reg[i] <= v[i][ELEM_W-1:0];
                end
            end
        end
    end

    assign out_valid = valid_reg[4];
    assign mat       = mat_reg;

endmodule

@@ sv/rotation_matrix_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix generator
// Axis-angle and plane rotation 4x4 matrices from angle and axis, one row per
// result transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries func, angle (Q4.16 radians) and axis_x/y/z (Q1.14). Each
//   accepted request yields four transfers on out_ch, rows 0 to 3 in order,
//   with last set on row 3; entries are Q3.14 and saturate.
//   A request reaches row 0 through three angle reduction stages, one stage
//   per CORDIC iteration, five matrix stages and the row output register.
//   Rows then follow one per cycle while out_ch.ready is high. Each request
//   holds the single output channel for its four rows. Requests may arrive
//   every cycle while the output register is empty; once it holds a matrix,
//   in_ch.ready is high only in the cycle its last row transfers.
//   When out_ch stalls, the row on the port holds and the whole pipeline
//   freezes in place once the output register is occupied; in_ch.ready
//   drops with it, so nothing is lost or repeated.
//   Reset clears all valid bits; no request is in flight afterward.
// ----------------------------------------------------------------------------
`include "rotation_matrix_generator_assert.svh"

module rotation_matrix_generator
    import rmg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rmg_in_if.sink    in_ch,
    rmg_out_if.source out_ch
);

    logic      en;
    logic      mat_valid_reg;
    logic [1:0] row_reg;
    rmg_mat_t  mat_reg;
    rmg_meta_t in_meta;

    logic                 red_valid;
    logic signed [CW-1:0] red_r;
    rmg_meta_t            red_meta;

    logic                 cv [CORDIC_STEPS+1];
    logic signed [CW-1:0] cx [CORDIC_STEPS+1];
    logic signed [CW-1:0] cy [CORDIC_STEPS+1];
    logic signed [CW-1:0] cr [CORDIC_STEPS+1];
    rmg_meta_t            cm [CORDIC_STEPS+1];

    logic     bld_valid;
    rmg_mat_t bld_mat;

    // Advance everything when the output register is free or its last row transfers
    assign en          = !mat_valid_reg || (out_ch.ready && row_reg == ROW_LAST);
    assign in_ch.ready = en;

    always_comb
    begin
        in_meta.func = in_ch.func;
        in_meta.ax   = in_ch.axis_x;
        in_meta.ay   = in_ch.axis_y;
        in_meta.az   = in_ch.axis_z;
        in_meta.neg  = 1'b0;
    end

    rmg_angle_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .angle     (in_ch.angle),
        .in_meta   (in_meta),
        .out_valid (red_valid),
        .r         (red_r),
        .out_meta  (red_meta)
    );

    assign cv[0] = red_valid;
    assign cx[0] = GAIN_Q30;
    assign cy[0] = '0;
    assign cr[0] = red_r;
    assign cm[0] = red_meta;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        rmg_cordic_stage #(.IDX(k)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[k]),
            .x_in      (cx[k]),
            .y_in      (cy[k]),
            .r_in      (cr[k]),
            .in_meta   (cm[k]),
            .out_valid (cv[k+1]),
            .x_out     (cx[k+1]),
            .y_out     (cy[k+1]),
            .r_out     (cr[k+1]),
            .out_meta  (cm[k+1])
        );
    end

    rmg_matrix_build #(.FRAC_BITS(FRAC_BITS)) u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cv[CORDIC_STEPS]),
        .x_in      (cx[CORDIC_STEPS]),
        .y_in      (cy[CORDIC_STEPS]),
        .in_meta   (cm[CORDIC_STEPS]),
        .out_valid (bld_valid),
        .mat       (bld_mat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else if (en)
        begin
            mat_valid_reg <= bld_valid;
            row_reg       <= '0;
        end
        else if (out_ch.ready)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg <= bld_mat;
        end
    end

    assign out_ch.valid = mat_valid_reg;
    assign out_ch.row   = row_reg;
    assign out_ch.elem0 = mat_reg[{row_reg, 2'd0}];
    assign out_ch.elem1 = mat_reg[{row_reg, 2'd1}];
    assign out_ch.elem2 = mat_reg[{row_reg, 2'd2}];
    assign out_ch.elem3 = mat_reg[{row_reg, 2'd3}];
    assign out_ch.last  = (row_reg == ROW_LAST);

    `RMG_ASSERT_NOW(a_ready_only_when_free,
        in_ch.ready && mat_valid_reg, out_ch.ready && row_reg == ROW_LAST,
        "request taken while output register still has rows")
    `RMG_ASSERT_NEXT(a_row_advance,
        out_ch.valid && out_ch.ready && row_reg != ROW_LAST,
        mat_valid_reg && row_reg == $past(row_reg) + 2'd1,
        "row transfer did not advance to the next row")
    `RMG_ASSERT_NEXT(a_drain_empty,
        out_ch.valid && out_ch.ready && out_ch.last && !bld_valid,
        !mat_valid_reg,
        "output register still valid after last row with no matrix behind")
    `RMG_ASSERT_NEXT(a_new_matrix_row0,
        en && bld_valid,
        mat_valid_reg && row_reg == 2'd0,
        "new matrix did not start at row 0")

endmodule

@@ bench/tb_rotation_matrix_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix generator testbench
// Sends directed and random requests in every mode and compares each matrix
// row with a bit-accurate prediction, under random gaps, stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_generator;
    import rmg_pkg::*;

    localparam int  STEPS     = CORDIC_STEPS_DEF;
    localparam int  FRAC      = FRAC_BITS_DEF;
    localparam int  N_RANDOM  = 90;
    localparam int  IDLE_MAX  = 20000;
    localparam int  DRAIN_CYC = STEPS + 40;

    typedef struct {
        logic [1:0]               row;
        logic signed [ELEM_W-1:0] e [4];
        logic                     last;
    } row_t;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [ANG_W-1:0]  angle;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
    } request_t;

    class matrix_scoreboard;
        row_t pending_rows[$];
        int   mismatches;

        function longint rnd_shift(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint qmul(longint a, longint b);
            return rnd_shift(a * b, WORK_BITS);
        endfunction

        function logic signed [ELEM_W-1:0] to_elem(longint q);
            longint v;
            if (FRAC <= WORK_BITS)
                v = (WORK_BITS == FRAC) ? q : rnd_shift(q, WORK_BITS - FRAC);
            else
                v = q * (64'sd1 <<< ((FRAC - WORK_BITS) & 7));
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            return v[ELEM_W-1:0];
        endfunction

        function void sine_cosine(longint ang, output longint s, output longint c);
            longint r, x, y, dx, dy, two_pi, pi_q, half_pi;
            bit     folded;
            two_pi  = TWO_PI_Q30;
            pi_q    = PI_Q30;
            half_pi = HALF_PI_Q30;
            r = ang * 16384;
            x = GAIN_Q30;
            y = 0;
            folded = 0;
            r = r % two_pi;
            if (r < 0) r += two_pi;
            if (r > pi_q) r -= two_pi;
            if (r > half_pi)
            begin
                r -= pi_q;
                folded = 1;
            end
            else if (r < -half_pi)
            begin
                r += pi_q;
                folded = 1;
            end
            for (int i = 0; i < STEPS && i < 32; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (r >= 0)
                begin
                    x -= dx; y += dy; r -= longint'(atan_q30(i[4:0]));
                end
                else
                begin
                    x += dx; y -= dy; r += longint'(atan_q30(i[4:0]));
                end
            end
            if (folded)
            begin
                x = -x; y = -y;
            end
            c = (x + 2) >>> 2;
            s = (y + 2) >>> 2;
        endfunction

        function int plane_axis(logic [FUNC_W-1:0] f, bit second);
            case (f)
                FUNC_XY: return second ? 1 : 0;
                FUNC_XZ: return second ? 2 : 0;
                FUNC_YZ: return second ? 2 : 1;
                FUNC_XW: return second ? 3 : 0;
                FUNC_ZW: return second ? 3 : 2;
                default: return second ? 3 : 1;
            endcase
        endfunction

        // Build the matrix for one request and queue its four rows.
        function void note_request(request_t q);
            longint m[4][4];
            longint one, s, c, x, y, z, omc, xy, xz, yz, xs, ys, zs;
            int     a, b;
            row_t   rw;
            one = 64'sd1 <<< WORK_BITS;
            sine_cosine(longint'(q.angle), s, c);
            for (int r = 0; r < 4; r++)
                for (int k = 0; k < 4; k++)
                    m[r][k] = (r == k) ? one : 0;
            if (q.func == FUNC_AXIS)
            begin
                x = longint'(q.ax) * 16384;
                y = longint'(q.ay) * 16384;
                z = longint'(q.az) * 16384;
                omc = one - c;
                xy = qmul(qmul(x, y), omc);
                xz = qmul(qmul(x, z), omc);
                yz = qmul(qmul(y, z), omc);
                xs = qmul(x, s); ys = qmul(y, s); zs = qmul(z, s);
                m[0][0] = qmul(qmul(x, x), omc) + c;
                m[0][1] = xy - zs;
                m[0][2] = xz + ys;
                m[1][0] = xy + zs;
                m[1][1] = qmul(qmul(y, y), omc) + c;
                m[1][2] = yz - xs;
                m[2][0] = xz - ys;
                m[2][1] = yz + xs;
                m[2][2] = qmul(qmul(z, z), omc) + c;
            end
            else if (q.func <= FUNC_YW)
            begin
                a = plane_axis(q.func, 0);
                b = plane_axis(q.func, 1);
                m[a][a] = c;
                m[a][b] = -s;
                m[b][a] = s;
                m[b][b] = c;
            end
            for (int r = 0; r < 4; r++)
            begin
                rw.row  = r[1:0];
                for (int k = 0; k < 4; k++)
                    rw.e[k] = to_elem(m[r][k]);
                rw.last = (r[1:0] == ROW_LAST);
                pending_rows.push_back(rw);
            end
        endfunction

        function void check_row(row_t got);
            row_t exp_row;
            bit   bad;
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row %0d: %0d %0d %0d %0d", got.row,
                             got.e[0], got.e[1], got.e[2], got.e[3]);
                return;
            end
            exp_row = pending_rows.pop_front();
            bad = (got.row !== exp_row.row) || (got.last !== exp_row.last);
            for (int k = 0; k < 4; k++)
                if (got.e[k] !== exp_row.e[k]) bad = 1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row mismatch: exp r%0d %0d %0d %0d %0d l%0d, got r%0d %0d %0d %0d %0d l%0d",
                             exp_row.row, exp_row.e[0], exp_row.e[1], exp_row.e[2],
                             exp_row.e[3], exp_row.last, got.row, got.e[0], got.e[1],
                             got.e[2], got.e[3], got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rmg_in_if  in_ch ();
    rmg_out_if out_ch ();

    rotation_matrix_generator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    matrix_scoreboard board;
    int  idle_cycles;
    bit  hold_off;
    bit  sending_done;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function logic signed [AXIS_W-1:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return AXIS_W'($urandom);
            default: return AXIS_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic send_request(request_t q);
        in_ch.func   <= q.func;
        in_ch.angle  <= q.angle;
        in_ch.axis_x <= q.ax;
        in_ch.axis_y <= q.ay;
        in_ch.axis_z <= q.az;
        in_ch.valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_request(q);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic make_request(logic [FUNC_W-1:0] f, int ang, int x, int y, int z,
                                output request_t q);
        q.func  = f;
        q.angle = ang[ANG_W-1:0];
        q.ax    = x[AXIS_W-1:0];
        q.ay    = y[AXIS_W-1:0];
        q.az    = z[AXIS_W-1:0];
    endtask

    initial
    begin
        request_t q;
        int       ang;
        board = new();
        rst_n = 1'b0;
        hold_off = 1'b0;
        sending_done = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_AXIS;
        in_ch.angle = '0;
        in_ch.axis_x = '0;
        in_ch.axis_y = '0;
        in_ch.axis_z = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every mode, angle extremes, axis extremes, unused mode.
        for (int f = 0; f < 8; f++)
        begin
            make_request(f[FUNC_W-1:0], 68629, 9459, 9459, 9459, q);
            send_request(q);
        end
        make_request(FUNC_AXIS, -524288, 16384, 0, 0, q);       send_request(q);
        make_request(FUNC_AXIS, 524287, 0, 16384, 0, q);        send_request(q);
        make_request(FUNC_AXIS, 0, -16384, -16384, -16384, q);  send_request(q);
        make_request(FUNC_AXIS, 205887, 32767, -32768, 32767, q); send_request(q);
        make_request(FUNC_AXIS, -205887, -32768, 32767, -32768, q); send_request(q);
        make_request(FUNC_XY, 102944, 0, 0, 0, q);              send_request(q);
        make_request(FUNC_XZ, -102944, 0, 0, 0, q);             send_request(q);
        make_request(FUNC_YZ, 411775, 0, 0, 0, q);              send_request(q);
        make_request(FUNC_XW, -411775, 0, 0, 0, q);             send_request(q);
        make_request(FUNC_ZW, 1, 0, 0, 0, q);                   send_request(q);
        make_request(3'd7, -1, -1, -1, -1, q);                  send_request(q);

        // Long output hold-off while the sender keeps pushing.
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            make_request(FUNC_AXIS, $urandom, rand_axis(), rand_axis(), rand_axis(), q);
            q.func = FUNC_W'($urandom_range(0, 7));
            fork
                send_request(q);
                begin
                    repeat (200) @(negedge clk);
                    hold_off = 1'b0;
                end
            join_any
            disable fork;
        end
        hold_off = 1'b0;

        for (int i = 0; i < N_RANDOM; i++)
        begin
            ang = ($urandom_range(0, 3) == 0) ? $urandom
                                              : $urandom_range(0, 823550) - 411775;
            make_request(FUNC_W'($urandom_range(0, 7)), ang, rand_axis(), rand_axis(),
                         rand_axis(), q);
            if ($urandom_range(0, 3) != 0) q.func = $urandom_range(0, 2) ? FUNC_AXIS : q.func;
            send_request(q);
            pause_sender();
        end
        in_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, plus the long hold-off.
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (150) @(negedge clk);
                wait (!hold_off);
                @(negedge clk);
            end
            n = gap_len();
            out_ch.ready <= (n == 0);
            repeat ((n == 0) ? $urandom_range(1, 8) : n) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        row_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.row  = out_ch.row;
            got.e[0] = out_ch.elem0;
            got.e[1] = out_ch.elem1;
            got.e[2] = out_ch.elem2;
            got.e[3] = out_ch.elem3;
            got.last = out_ch.last;
            board.check_row(got);
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        fork
            begin
                wait (sending_done && board.pending_rows.size() == 0);
                repeat (DRAIN_CYC) @(posedge clk);
            end
            wait (idle_cycles >= IDLE_MAX);
        join_any
        if (idle_cycles >= IDLE_MAX || board.pending_rows.size() != 0)
            board.mismatches++;
        if (board.mismatches == 0)
            $display("tb_rotation_matrix_generator: clean");
        else
            $display("tb_rotation_matrix_generator: errors");
        $finish;
    end

endmodule
